// File: rtl/core/sasp_pkg.sv
// ----------------------------------------------------------------------------
// sasp_pkg
// Shared types and constants of the socket address string parser.
// ----------------------------------------------------------------------------
package sasp_pkg;

   // Host name buffer size; a host name must be shorter than this (2..256).
   localparam int HOST_BUFFER_BYTES = 256;
   localparam int HOST_COUNT_BITS   = $clog2(HOST_BUFFER_BYTES + 1);

   // Queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;

   localparam logic [8:0]  OCTET_MAX = 9'd255;
   localparam logic [8:0]  OCTET_SAT = 9'd256;
   localparam logic [16:0] PORT_MAX  = 17'd65535;
   localparam logic [16:0] PORT_SAT  = 17'd65536;

   // Radix codes
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   // Octet sub-phase codes
   localparam logic [1:0] SUB_START  = 2'd0;
   localparam logic [1:0] SUB_ZERO   = 2'd1;
   localparam logic [1:0] SUB_XPFX   = 2'd2;
   localparam logic [1:0] SUB_DIGITS = 2'd3;

   // Dotted reading outcome codes
   localparam logic [1:0] OUT_PENDING = 2'd0;
   localparam logic [1:0] OUT_FAILED  = 2'd1;
   localparam logic [1:0] OUT_OK      = 2'd2;
   localparam logic [1:0] OUT_BAD     = 2'd3;

   // Port phase codes
   localparam logic [2:0] PP_BEFORE = 3'd0;
   localparam logic [2:0] PP_SPACE  = 3'd1;
   localparam logic [2:0] PP_SIGN   = 3'd2;
   localparam logic [2:0] PP_ZERO   = 3'd3;
   localparam logic [2:0] PP_XPFX   = 3'd4;
   localparam logic [2:0] PP_DIGITS = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_INVALID = 2'd0;
   localparam logic [1:0] STATUS_DOTTED  = 2'd1;
   localparam logic [1:0] STATUS_HOST    = 2'd2;

   // Classified byte as handed from front to back
   typedef struct packed {
      logic [3:0] digit;      // hex digit value, valid when is_hex
      logic       is_hex;
      logic       is_x;
      logic       is_colon;
      logic       is_dot;
      logic       is_end;
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
   } char_class_type;

endpackage

// File: rtl/core/socket_address_string_parser.sv
// ----------------------------------------------------------------------------
// socket_address_string_parser
// Parses "a.b.c.d[:port]" or "host[:port]" one byte per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_char_code[7:0]
//  rsp     | out       | rsp_valid/rsp_stall | status, octet_a..d, port_given,
//          |           |                     | port_number, host_length
//
//  One byte per cycle while no zero byte waits on rsp_stall; a zero byte
//  yields a result the cycle after the back end takes it from the two-entry
//  queue. Front classifies bytes and pushes them into the queue; the back end
//  updates the parser state and holds one result register.
//  req_stall rises only when the queue is full; the back end keeps taking
//  non-terminating bytes while a result waits on rsp_stall.
//  Synchronous reset clears the queue, the parser state and rsp_valid.
// ----------------------------------------------------------------------------
module socket_address_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_octet_a,
   output logic [7:0]  rsp_octet_b,
   output logic [7:0]  rsp_octet_c,
   output logic [7:0]  rsp_octet_d,
   output logic        rsp_port_given,
   output logic [15:0] rsp_port_number,
   output logic [7:0]  rsp_host_length
);

   logic                     queue_full, push, pop, head_valid;
   sasp_pkg::char_class_type push_class, head_class;

   sasp_front u_front (
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .req_stall     (req_stall),
      .queue_full    (queue_full),
      .push          (push),
      .push_class    (push_class)
   );

   sasp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_class (push_class),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_class (head_class)
   );

   sasp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_class      (head_class),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_octet_a     (rsp_octet_a),
      .rsp_octet_b     (rsp_octet_b),
      .rsp_octet_c     (rsp_octet_c),
      .rsp_octet_d     (rsp_octet_d),
      .rsp_port_given  (rsp_port_given),
      .rsp_port_number (rsp_port_number),
      .rsp_host_length (rsp_host_length)
   );

endmodule

// File: rtl/core/sasp_front.sv
// ----------------------------------------------------------------------------
// sasp_front
// Accepts string bytes and classifies them for the parser back end.
// ----------------------------------------------------------------------------
module sasp_front (
   input  logic                           req_valid,
   input  logic [7:0]                     req_char_code,
   output logic                           req_stall,
   input  logic                           queue_full,
   output logic                           push,
   output sasp_pkg::char_class_type       push_class
);

   logic [7:0] c;

   assign c         = req_char_code;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_class        = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         push_class.is_hex = 1'b1;
         push_class.digit  = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         push_class.is_hex = 1'b1;
         push_class.digit  = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         push_class.is_hex = 1'b1;
         push_class.digit  = 4'(c - 8'h37);
      end
      push_class.is_x     = (c == sasp_pkg::CHAR_LOWER_X) || (c == sasp_pkg::CHAR_UPPER_X);
      push_class.is_colon = (c == sasp_pkg::CHAR_COLON);
      push_class.is_dot   = (c == sasp_pkg::CHAR_DOT);
      push_class.is_end   = (c == 8'h00);
      push_class.is_space = (c == sasp_pkg::CHAR_SPACE) ||
                            (c >= sasp_pkg::CHAR_TAB && c <= sasp_pkg::CHAR_CR);
      push_class.is_plus  = (c == sasp_pkg::CHAR_PLUS);
      push_class.is_minus = (c == sasp_pkg::CHAR_MINUS);
   end

endmodule

// File: rtl/core/sasp_queue.sv
// ----------------------------------------------------------------------------
// sasp_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sasp_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  sasp_pkg::char_class_type               push_class,
   input  logic                                   pop,
   output logic                                   full,
   output logic                                   head_valid,
   output sasp_pkg::char_class_type               head_class
);

   sasp_pkg::char_class_type                    entry_ff [sasp_pkg::QUEUE_DEPTH];
   logic [sasp_pkg::QUEUE_PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sasp_pkg::QUEUE_PTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sasp_pkg::QUEUE_COUNT_BITS-1:0]       count_ff, count_in;
   logic                                        do_push, do_pop;

   assign full       = (count_ff == sasp_pkg::QUEUE_COUNT_BITS'(sasp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_class = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule

// File: rtl/core/sasp_back.sv
// ----------------------------------------------------------------------------
// sasp_back
// Dotted address, host name and port parsing; holds the result register.
// ----------------------------------------------------------------------------
module sasp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  sasp_pkg::char_class_type       head_class,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_octet_a,
   output logic [7:0]                     rsp_octet_b,
   output logic [7:0]                     rsp_octet_c,
   output logic [7:0]                     rsp_octet_d,
   output logic                           rsp_port_given,
   output logic [15:0]                    rsp_port_number,
   output logic [7:0]                     rsp_host_length
);

   localparam int HCB = sasp_pkg::HOST_COUNT_BITS;

   sasp_pkg::char_class_type cls;

   // parser state
   logic [1:0]     oct_idx_ff, oct_idx_in;
   logic [1:0]     oct_sub_ff, oct_sub_in;
   logic [1:0]     outcome_ff, outcome_in;
   logic [1:0]     oct_radix_ff, oct_radix_in;
   logic [8:0]     oct_acc_ff, oct_acc_in;
   logic [7:0]     store_ff [4];
   logic [7:0]     store_in [4];
   logic [HCB-1:0] host_count_ff, host_count_in;
   logic [2:0]     port_phase_ff, port_phase_in;
   logic [1:0]     port_radix_ff, port_radix_in;
   logic           port_neg_ff, port_neg_in;
   logic [16:0]    port_acc_ff, port_acc_in;
   logic           failed_ff, failed_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     status_ff;
   logic [7:0]     octet_ff [4];
   logic           given_ff;
   logic [15:0]    port_ff;
   logic [7:0]     hlen_ff;

   logic           out_free, load_result;
   logic [1:0]     res_status;
   logic           res_given;
   logic [15:0]    res_port;
   logic [7:0]     res_hlen;
   logic           has_colon, port_ok, close_now, port_first;

   logic           oct_digit_ok, port_digit_ok;
   logic [12:0]    oct_mac;
   logic [20:0]    port_mac;

   assign cls         = head_class;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = head_valid && (!head_class.is_end || out_free);
   assign load_result = pop && cls.is_end;

   // digit within radix
   always_comb begin
      case (oct_radix_ff)
         sasp_pkg::RADIX_OCT: oct_digit_ok = cls.is_hex && (cls.digit < 4'd8);
         sasp_pkg::RADIX_HEX: oct_digit_ok = cls.is_hex;
         default:             oct_digit_ok = cls.is_hex && (cls.digit < 4'd10);
      endcase
      case (port_radix_ff)
         sasp_pkg::RADIX_OCT: port_digit_ok = cls.is_hex && (cls.digit < 4'd8);
         sasp_pkg::RADIX_HEX: port_digit_ok = cls.is_hex;
         default:             port_digit_ok = cls.is_hex && (cls.digit < 4'd10);
      endcase
   end

   // accumulate: acc * radix + digit, radix by shifts
   always_comb begin
      case (oct_radix_ff)
         sasp_pkg::RADIX_OCT: oct_mac = {1'b0, oct_acc_ff, 3'b0};
         sasp_pkg::RADIX_HEX: oct_mac = {oct_acc_ff, 4'b0};
         default:             oct_mac = {1'b0, oct_acc_ff, 3'b0} + {3'b0, oct_acc_ff, 1'b0};
      endcase
      oct_mac = oct_mac + 13'(cls.digit);
      case (port_radix_ff)
         sasp_pkg::RADIX_OCT: port_mac = {1'b0, port_acc_ff, 3'b0};
         sasp_pkg::RADIX_HEX: port_mac = {port_acc_ff, 4'b0};
         default:             port_mac = {1'b0, port_acc_ff, 3'b0} + {3'b0, port_acc_ff, 1'b0};
      endcase
      port_mac = port_mac + 21'(cls.digit);
   end

   always_comb begin
      oct_idx_in    = oct_idx_ff;
      oct_sub_in    = oct_sub_ff;
      outcome_in    = outcome_ff;
      oct_radix_in  = oct_radix_ff;
      oct_acc_in    = oct_acc_ff;
      for (int k = 0; k < 4; k++) store_in[k] = store_ff[k];
      host_count_in = host_count_ff;
      port_phase_in = port_phase_ff;
      port_radix_in = port_radix_ff;
      port_neg_in   = port_neg_ff;
      port_acc_in   = port_acc_ff;
      failed_in     = failed_ff;
      close_now     = 1'b0;
      port_first    = 1'b0;
      has_colon     = 1'b0;
      port_ok       = 1'b0;
      res_status    = sasp_pkg::STATUS_INVALID;
      res_given     = 1'b0;
      res_port      = '0;
      res_hlen      = '0;

      if (pop) begin
         // dotted address reading
         if (outcome_ff == sasp_pkg::OUT_PENDING) begin
            case (oct_sub_ff)
               sasp_pkg::SUB_START: begin
                  if (cls.is_hex && cls.digit < 4'd10) begin
                     oct_acc_in   = 9'(cls.digit);
                     oct_radix_in = sasp_pkg::RADIX_DEC;
                     oct_sub_in   = (cls.digit == 4'd0) ? sasp_pkg::SUB_ZERO
                                                        : sasp_pkg::SUB_DIGITS;
                  end else begin
                     outcome_in = sasp_pkg::OUT_FAILED;
                  end
               end
               sasp_pkg::SUB_ZERO: begin
                  if (cls.is_x) begin
                     oct_sub_in = sasp_pkg::SUB_XPFX;
                  end else if (cls.is_hex && cls.digit < 4'd8) begin
                     oct_radix_in = sasp_pkg::RADIX_OCT;
                     oct_acc_in   = 9'(cls.digit);
                     oct_sub_in   = sasp_pkg::SUB_DIGITS;
                  end else begin
                     close_now = 1'b1;
                  end
               end
               sasp_pkg::SUB_XPFX: begin
                  if (cls.is_hex) begin
                     oct_radix_in = sasp_pkg::RADIX_HEX;
                     oct_acc_in   = 9'(cls.digit);
                     oct_sub_in   = sasp_pkg::SUB_DIGITS;
                  end else begin
                     outcome_in = (oct_idx_ff != 2'd3) ? sasp_pkg::OUT_FAILED
                                                       : sasp_pkg::OUT_BAD;
                  end
               end
               default: begin
                  if (oct_digit_ok) begin
                     oct_acc_in = (oct_mac > 13'(sasp_pkg::OCTET_SAT)) ?
                                  sasp_pkg::OCTET_SAT : oct_mac[8:0];
                  end else begin
                     close_now = 1'b1;
                  end
               end
            endcase

            if (close_now) begin
               if (oct_acc_ff > sasp_pkg::OCTET_MAX) begin
                  outcome_in = sasp_pkg::OUT_FAILED;
               end else begin
                  store_in[oct_idx_ff] = oct_acc_ff[7:0];
                  if (oct_idx_ff != 2'd3) begin
                     if (cls.is_dot) begin
                        oct_idx_in   = oct_idx_ff + 2'd1;
                        oct_sub_in   = sasp_pkg::SUB_START;
                        oct_acc_in   = '0;
                        oct_radix_in = sasp_pkg::RADIX_DEC;
                     end else begin
                        outcome_in = sasp_pkg::OUT_FAILED;
                     end
                  end else begin
                     outcome_in = (cls.is_colon || cls.is_end) ? sasp_pkg::OUT_OK
                                                               : sasp_pkg::OUT_BAD;
                  end
               end
            end
         end

         if (!cls.is_end) begin
            if (port_phase_ff == sasp_pkg::PP_BEFORE) begin
               if (cls.is_colon) begin
                  port_phase_in = sasp_pkg::PP_SPACE;
               end else if (host_count_ff < HCB'(sasp_pkg::HOST_BUFFER_BYTES)) begin
                  host_count_in = host_count_ff + 1'b1;
               end
            end else if (!failed_ff) begin
               case (port_phase_ff)
                  sasp_pkg::PP_SPACE: begin
                     if (cls.is_space) begin
                        port_phase_in = port_phase_ff;
                     end else if (cls.is_plus) begin
                        port_phase_in = sasp_pkg::PP_SIGN;
                     end else if (cls.is_minus) begin
                        port_neg_in   = 1'b1;
                        port_phase_in = sasp_pkg::PP_SIGN;
                     end else begin
                        port_first = 1'b1;
                     end
                  end
                  sasp_pkg::PP_SIGN: port_first = 1'b1;
                  sasp_pkg::PP_ZERO: begin
                     if (cls.is_x) begin
                        port_phase_in = sasp_pkg::PP_XPFX;
                     end else if (cls.is_hex && cls.digit < 4'd8) begin
                        port_radix_in = sasp_pkg::RADIX_OCT;
                        port_acc_in   = 17'(cls.digit);
                        port_phase_in = sasp_pkg::PP_DIGITS;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  sasp_pkg::PP_XPFX: begin
                     if (cls.is_hex) begin
                        port_radix_in = sasp_pkg::RADIX_HEX;
                        port_acc_in   = 17'(cls.digit);
                        port_phase_in = sasp_pkg::PP_DIGITS;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  default: begin
                     if (port_digit_ok) begin
                        port_acc_in = (port_mac > 21'(sasp_pkg::PORT_SAT)) ?
                                      sasp_pkg::PORT_SAT : port_mac[16:0];
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
               endcase

               // first character of the number after whitespace or sign
               if (port_first) begin
                  if (cls.is_hex && cls.digit == 4'd0) begin
                     port_acc_in   = '0;
                     port_phase_in = sasp_pkg::PP_ZERO;
                  end else if (cls.is_hex && cls.digit < 4'd10) begin
                     port_radix_in = sasp_pkg::RADIX_DEC;
                     port_acc_in   = 17'(cls.digit);
                     port_phase_in = sasp_pkg::PP_DIGITS;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
            end
         end else begin
            has_colon = (port_phase_ff != sasp_pkg::PP_BEFORE);
            port_ok   = has_colon && !failed_ff &&
                        (port_phase_ff == sasp_pkg::PP_ZERO ||
                         port_phase_ff == sasp_pkg::PP_DIGITS) &&
                        (!port_neg_ff || port_acc_ff == '0) &&
                        (port_acc_ff <= sasp_pkg::PORT_MAX);

            if (outcome_in == sasp_pkg::OUT_OK) begin
               if (!has_colon || port_ok) res_status = sasp_pkg::STATUS_DOTTED;
            end else if (outcome_in == sasp_pkg::OUT_FAILED) begin
               if (host_count_ff != '0 &&
                   host_count_ff < HCB'(sasp_pkg::HOST_BUFFER_BYTES) &&
                   (!has_colon || port_ok)) begin
                  res_status = sasp_pkg::STATUS_HOST;
                  res_hlen   = 8'(host_count_ff);
               end
            end
            if (res_status != sasp_pkg::STATUS_INVALID && has_colon) begin
               res_given = 1'b1;
               res_port  = port_acc_ff[15:0];
            end

            // clear for the next string
            oct_idx_in    = '0;
            oct_sub_in    = sasp_pkg::SUB_START;
            outcome_in    = sasp_pkg::OUT_PENDING;
            oct_radix_in  = sasp_pkg::RADIX_DEC;
            oct_acc_in    = '0;
            host_count_in = '0;
            port_phase_in = sasp_pkg::PP_BEFORE;
            port_radix_in = sasp_pkg::RADIX_DEC;
            port_neg_in   = 1'b0;
            port_acc_in   = '0;
            failed_in     = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_idx_ff    <= '0;
         oct_sub_ff    <= sasp_pkg::SUB_START;
         outcome_ff    <= sasp_pkg::OUT_PENDING;
         oct_radix_ff  <= sasp_pkg::RADIX_DEC;
         oct_acc_ff    <= '0;
         for (int k = 0; k < 4; k++) store_ff[k] <= '0;
         host_count_ff <= '0;
         port_phase_ff <= sasp_pkg::PP_BEFORE;
         port_radix_ff <= sasp_pkg::RADIX_DEC;
         port_neg_ff   <= 1'b0;
         port_acc_ff   <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         oct_idx_ff    <= oct_idx_in;
         oct_sub_ff    <= oct_sub_in;
         outcome_ff    <= outcome_in;
         oct_radix_ff  <= oct_radix_in;
         oct_acc_ff    <= oct_acc_in;
         // stored octets are read only with an OK outcome, so they clear lazily
         for (int k = 0; k < 4; k++) store_ff[k] <= store_in[k];
         host_count_ff <= host_count_in;
         port_phase_ff <= port_phase_in;
         port_radix_ff <= port_radix_in;
         port_neg_ff   <= port_neg_in;
         port_acc_ff   <= port_acc_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         status_ff <= res_status;
         for (int k = 0; k < 4; k++) begin
            octet_ff[k] <= (res_status == sasp_pkg::STATUS_DOTTED) ? store_in[k] : 8'd0;
         end
         given_ff  <= res_given;
         port_ff   <= res_port;
         hlen_ff   <= res_hlen;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_octet_a     = octet_ff[0];
   assign rsp_octet_b     = octet_ff[1];
   assign rsp_octet_c     = octet_ff[2];
   assign rsp_octet_d     = octet_ff[3];
   assign rsp_port_given  = given_ff;
   assign rsp_port_number = port_ff;
   assign rsp_host_length = hlen_ff;

   // a terminator leaves the parser cleared
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      load_result |=> (outcome_ff == sasp_pkg::OUT_PENDING &&
                       port_phase_ff == sasp_pkg::PP_BEFORE &&
                       host_count_ff == '0 && !failed_ff))
      else $error("parser state not cleared after end of string");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sasp_pkg::STATUS_INVALID) |->
         (!rsp_port_given && rsp_port_number == '0 && rsp_host_length == '0 &&
          rsp_octet_a == '0 && rsp_octet_d == '0))
      else $error("invalid result carries nonzero fields");

   a_host_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sasp_pkg::STATUS_HOST) |->
         (rsp_host_length != '0 && rsp_octet_a == '0 && rsp_octet_b == '0))
      else $error("host name result malformed");

   a_acc_bounds: assert property (@(posedge clock) disable iff (reset)
      (oct_acc_ff <= sasp_pkg::OCTET_SAT && port_acc_ff <= sasp_pkg::PORT_SAT &&
       host_count_ff <= HCB'(sasp_pkg::HOST_BUFFER_BYTES)))
      else $error("accumulator beyond saturation");

endmodule
